// ===== src/mrw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrw_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] base;
  } in_t;

  typedef struct packed {
    logic              probable_prime;
    logic              root_found;
    logic [DATA_W-1:0] power_value;
    logic              bad_input;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ_GO,
    ST_SQ_RUN,
    ST_MUL_GO,
    ST_MUL_RUN,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_start;
    logic sq_take;
    logic mul_start;
    logic mul_take;
    logic next_bit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic mul_done;
    logic ebit;
    logic last_bit;
  } status_t;

endpackage

`default_nettype wire

// ===== src/mrw_modmul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrw_modmul #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] op_x,
  input  wire logic [WIDTH-1:0] op_y,
  input  wire logic [WIDTH-1:0] modulus,
  output logic                  done,
  output logic [WIDTH-1:0]      result
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [WIDTH:0] dbl;
  logic [WIDTH:0] dbl_red;
  logic [WIDTH:0] sum;
  logic [WIDTH:0] sum_red;

  // shift-and-add, multiplier bits from the top, reduced every step
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    sum     = dbl_red + {1'b0, x_r};
    if (!y_r[WIDTH-1]) begin
      sum = dbl_red;
    end
    sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
    acc_nxt = sum_red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(WIDTH - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= op_x;
      y_r   <= op_y;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[WIDTH-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

// ===== src/mrw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrw_datapath #(
  parameter int WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mrw_pkg::in_t  in_item,
  input  wire mrw_pkg::cmd_t cmd,
  output mrw_pkg::status_t   status,
  output mrw_pkg::out_t      out_item
);

  import mrw_pkg::*;

  localparam int IDX_W = $clog2(WIDTH);

  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] e_r;
  logic [WIDTH-1:0] x_r;
  logic [IDX_W-1:0] idx_r;
  logic             root_r;
  logic             bad_r;

  logic [WIDTH-1:0] in_m;
  logic [WIDTH-1:0] in_a;
  logic             in_bad;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] mul_res;
  logic             mul_done;

  assign in_m   = in_item.modulus[WIDTH-1:0];
  assign in_a   = in_item.base[WIDTH-1:0];
  assign in_bad = (in_m < WIDTH'(4)) || (in_a < WIDTH'(2)) || (in_a > in_m - WIDTH'(2));

  assign mul_y = cmd.mul_start ? a_r : x_r;

  mrw_modmul #(
    .WIDTH (WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sq_start || cmd.mul_start),
    .op_x    (x_r),
    .op_y    (mul_y),
    .modulus (m_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r    <= in_m;
      a_r    <= in_a;
      e_r    <= in_m - WIDTH'(1);
      x_r    <= WIDTH'(1);
      idx_r  <= IDX_W'(WIDTH - 1);
      root_r <= 1'b0;
      bad_r  <= in_bad;
    end else begin
      if (cmd.sq_take) begin
        x_r <= mul_res;
        if (mul_res == WIDTH'(1) && x_r != WIDTH'(1) && x_r != m_r - WIDTH'(1)) begin
          root_r <= 1'b1;
        end
      end else if (cmd.mul_take) begin
        x_r <= mul_res;
      end
      if (cmd.next_bit) begin
        e_r   <= {e_r[WIDTH-2:0], 1'b0};
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  always_comb begin
    status.bad      = bad_r;
    status.mul_done = mul_done;
    status.ebit     = e_r[WIDTH-1];
    status.last_bit = (idx_r == '0);
  end

  always_comb begin
    out_item.bad_input      = bad_r;
    out_item.root_found     = !bad_r && root_r;
    out_item.probable_prime = !bad_r && !root_r && (x_r == WIDTH'(1));
    out_item.power_value    = bad_r ? '0 : DATA_W'(x_r);
  end

endmodule

`default_nettype wire

// ===== src/mrw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire mrw_pkg::status_t status,
  output mrw_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  out_valid
);

  import mrw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.bad ? ST_DONE : ST_SQ_GO;
      end
      ST_SQ_GO: begin
        cmd.sq_start = 1'b1;
        state_nxt    = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        if (status.mul_done) begin
          cmd.sq_take = 1'b1;
          state_nxt   = status.ebit ? ST_MUL_GO : ST_STEP;
        end
      end
      ST_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        if (status.mul_done) begin
          cmd.mul_take = 1'b1;
          state_nxt    = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status.last_bit) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.next_bit = 1'b1;
          state_nxt    = ST_SQ_GO;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/miller_rabin_witness_test_core.sv =====
// channel   ports                     handshake
// input     in_item (modulus, base)   taken when start && !busy
// result    out_item                  shown for one cycle while out_valid is high
//
// one item at a time; modular multiplies run in the single shared
// shift-and-add unit, one square per exponent bit plus one multiply per set bit
// bad input skips the exponentiation and goes straight from the check state to done
// busy drops the cycle after out_valid, when the next item can be taken
// synchronous active-low reset returns the controller to idle
// out_valid is a one-cycle strobe; the receiver cannot stall the block
`timescale 1ns / 1ps
`default_nettype none

module miller_rabin_witness_test_core #(
  parameter int WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire mrw_pkg::in_t in_item,
  output logic              busy,
  output logic              out_valid,
  output mrw_pkg::out_t     out_item
);

  import mrw_pkg::*;

  cmd_t    cmd;
  status_t status;

  mrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mrw_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== sim/miller_rabin_witness_test_core_tb.sv =====
`timescale 1ns / 1ps

module miller_rabin_witness_test_core_tb;
  import mrw_pkg::*;

  localparam int WIDTH = 32;
  localparam int RANDOM_ITEMS = 270;
  localparam int QUIET_TAIL = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  in_t tests_q[$];
  out_t verdicts_q[$];
  int mismatches = 0;
  int gap_left = 0;
  bit bursty = 1'b1;

  int unsigned known_primes[] = '{5, 7, 13, 97, 257, 7919, 65521, 65537, 999983,
                                  2147483647, 4294967291, 4294967279, 3221225473};

  miller_rabin_witness_test_core #(.WIDTH(WIDTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always #1 clk = ~clk;

  function automatic out_t mr_witness_verdict(in_t it);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] x;
    logic [63:0] sq;
    bit root;
    out_t r;
    m = 64'(it.modulus) & ((64'd1 << WIDTH) - 64'd1);
    a = 64'(it.base) & ((64'd1 << WIDTH) - 64'd1);
    r = '0;
    root = 1'b0;
    if (m < 64'd4 || a < 64'd2 || a > m - 64'd2) begin
      r.bad_input = 1'b1;
      return r;
    end
    e = m - 64'd1;
    x = 64'd1;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      sq = (x * x) % m;
      if (sq == 64'd1 && x != 64'd1 && x != m - 64'd1)
        root = 1'b1;
      if (e[i])
        sq = (sq * a) % m;
      x = sq;
    end
    r.probable_prime = !root && x == 64'd1;
    r.root_found = root;
    r.power_value = x[DATA_W-1:0];
    return r;
  endfunction

  function automatic in_t witness_pair(logic [DATA_W-1:0] m, logic [DATA_W-1:0] a);
    in_t it;
    it.modulus = m;
    it.base = a;
    return it;
  endfunction

  function automatic in_t random_test();
    int unsigned kind;
    int unsigned m;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      case ($urandom_range(0, 2))
        0: return witness_pair($urandom_range(0, 3), $urandom());
        1: return witness_pair($urandom(), $urandom_range(0, 1));
        default: begin
          m = $urandom_range(32'hFFFF_FFFF, 4);
          return witness_pair(m, $urandom_range(32'hFFFF_FFFF, m - 1));
        end
      endcase
    end
    if (kind < 22)
      m = known_primes[$urandom_range(0, known_primes.size() - 1)];
    else if (kind < 38)
      m = $urandom_range(1000, 4);
    else
      m = $urandom_range(32'hFFFF_FFFF, 4);
    return witness_pair(m, $urandom_range(m - 2, 2));
  endfunction

  task automatic report_mismatch(string what, out_t want, out_t got);
    if (mismatches < 10)
      $display("%0t: %s: expected prime=%0b root=%0b power=%h bad=%0b, got prime=%0b root=%0b power=%h bad=%0b",
               $realtime, what, want.probable_prime, want.root_found, want.power_value,
               want.bad_input, got.probable_prime, got.root_found, got.power_value,
               got.bad_input);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) begin
        verdicts_q.push_back(mr_witness_verdict(in_item));
        void'(tests_q.pop_front());
        if ($urandom_range(0, 19) == 0)
          bursty = !bursty;
      end
      if (gap_left == 0 && bursty && tests_q.size() > QUIET_TAIL &&
          $urandom_range(0, 15) == 0)
        gap_left = $urandom_range(1, 13);
      if (gap_left > 0 || tests_q.size() == 0) begin
        if (gap_left > 0)
          gap_left--;
        start <= 1'b0;
        in_item <= witness_pair($urandom(), $urandom());
      end else begin
        start <= 1'b1;
        in_item <= tests_q[0];
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdicts_q.size() == 0) begin
        report_mismatch("result with no item pending", '0, out_item);
      end else begin
        out_t want;
        want = verdicts_q.pop_front();
        if (out_item.probable_prime !== want.probable_prime ||
            out_item.root_found !== want.root_found ||
            out_item.power_value !== want.power_value ||
            out_item.bad_input !== want.bad_input)
          report_mismatch("result mismatch", want, out_item);
      end
    end
  end

  initial begin
    // modulus below four
    tests_q.push_back(witness_pair(32'd0, 32'd2));
    tests_q.push_back(witness_pair(32'd1, 32'd0));
    tests_q.push_back(witness_pair(32'd2, 32'd2));
    tests_q.push_back(witness_pair(32'd3, 32'hFFFF_FFFF));
    // base range edges
    tests_q.push_back(witness_pair(32'd4, 32'd2));
    tests_q.push_back(witness_pair(32'd5, 32'd1));
    tests_q.push_back(witness_pair(32'd5, 32'd2));
    tests_q.push_back(witness_pair(32'd5, 32'd3));
    tests_q.push_back(witness_pair(32'd5, 32'd4));
    tests_q.push_back(witness_pair(32'd97, 32'd0));
    // pseudoprimes and carmichael numbers
    tests_q.push_back(witness_pair(32'd341, 32'd2));
    tests_q.push_back(witness_pair(32'd561, 32'd2));
    tests_q.push_back(witness_pair(32'd2047, 32'd2));
    tests_q.push_back(witness_pair(32'd1729, 32'd5));
    // even modulus
    tests_q.push_back(witness_pair(32'd1000, 32'd7));
    tests_q.push_back(witness_pair(32'h8000_0000, 32'd3));
    // full-width operands
    tests_q.push_back(witness_pair(32'hFFFF_FFFB, 32'd2));
    tests_q.push_back(witness_pair(32'hFFFF_FFFB, 32'hFFFF_FFF9));
    tests_q.push_back(witness_pair(32'hFFFF_FFFB, 32'hFFFF_FFFA));
    tests_q.push_back(witness_pair(32'hFFFF_FFFF, 32'hFFFF_FFFD));
    tests_q.push_back(witness_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE));
    tests_q.push_back(witness_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    tests_q.push_back(witness_pair(32'h7FFF_FFFF, 32'h5555_5555));
    for (int i = 0; i < RANDOM_ITEMS; i++)
      tests_q.push_back(random_test());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (tests_q.size() != 0 || verdicts_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && verdicts_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mrw_pkg.sv
src/mrw_modmul.sv
src/mrw_datapath.sv
src/mrw_ctrl.sv
src/miller_rabin_witness_test_core.sv
sim/miller_rabin_witness_test_core_tb.sv
